FILE: hdl/wps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wps_pkg;

    // result kind codes
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_END_OK = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // input op codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_EOF  = 1'b1;

    // chunk tags, first byte of the file in the high bits
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    // format requirements
    localparam logic [15:0] FMT_PCM      = 16'd1;
    localparam logic [15:0] BITS_16      = 16'd16;
    localparam logic [15:0] CHAN_MONO    = 16'd1;
    localparam logic [15:0] CHAN_STEREO  = 16'd2;
    localparam logic [31:0] FMT_MIN_LEN  = 32'd16;

    // parser phases
    typedef enum logic [9:0] {
        PH_RIFF_TAG  = 10'b00_0000_0001,
        PH_RIFF_SIZE = 10'b00_0000_0010,
        PH_WAVE_TAG  = 10'b00_0000_0100,
        PH_HDR_PRE   = 10'b00_0000_1000,
        PH_SKIP_PRE  = 10'b00_0001_0000,
        PH_FMT_BODY  = 10'b00_0010_0000,
        PH_HDR_POST  = 10'b00_0100_0000,
        PH_SKIP_POST = 10'b00_1000_0000,
        PH_DATA      = 10'b01_0000_0000,
        PH_DONE      = 10'b10_0000_0000
    } t_phase;

    // one queued result group: dual sends the sample in the left then right slot
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] sample;
        logic               right;
        logic               dual;
    } t_entry;

endpackage

`default_nettype wire

FILE: hdl/wps_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module wps_parser (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic          i_op,
    input  wire logic [7:0]    i_byte,
    output wps_pkg::t_entry    o_entry,
    output logic               o_push
);

    wps_pkg::t_phase    r_phase, n_phase;
    logic [3:0]         r_byte_index, n_byte_index;
    logic [31:0]        r_tag_word, n_tag_word;
    logic [31:0]        r_chunk_length, n_chunk_length;
    logic [31:0]        r_skip_remaining, n_skip_remaining;
    logic [15:0]        r_format_code, n_format_code;
    logic [15:0]        r_channel_count, n_channel_count;
    logic [15:0]        r_sample_bits, n_sample_bits;
    logic [7:0]         r_low_byte_hold, n_low_byte_hold;
    logic               r_byte_parity, n_byte_parity;
    logic               r_stereo_slot, n_stereo_slot;

    logic [31:0]        shifted_tag;
    logic [31:0]        placed_len;
    logic [15:0]        full_bits;
    logic [3:0]         index_inc;

    assign shifted_tag = {r_tag_word[23:0], i_byte};
    assign placed_len  = r_chunk_length | ({24'd0, i_byte} << {r_byte_index[1:0], 3'b000});
    assign full_bits   = {i_byte, r_sample_bits[7:0]};
    assign index_inc   = r_byte_index + 4'd1;

    // next state and result for one beat
    always_comb begin
        n_phase          = r_phase;
        n_byte_index     = r_byte_index;
        n_tag_word       = r_tag_word;
        n_chunk_length   = r_chunk_length;
        n_skip_remaining = r_skip_remaining;
        n_format_code    = r_format_code;
        n_channel_count  = r_channel_count;
        n_sample_bits    = r_sample_bits;
        n_low_byte_hold  = r_low_byte_hold;
        n_byte_parity    = r_byte_parity;
        n_stereo_slot    = r_stereo_slot;
        o_push           = 1'b0;
        o_entry.kind     = wps_pkg::KIND_ERROR;
        o_entry.sample   = '0;
        o_entry.right    = 1'b0;
        o_entry.dual     = 1'b0;

        if (i_op == wps_pkg::OP_EOF) begin
            // end of file: report unless an error was already reported, and return to reset state
            o_push           = (r_phase != wps_pkg::PH_DONE);
            o_entry.kind     = (r_phase == wps_pkg::PH_DATA) ? wps_pkg::KIND_END_OK
                                                              : wps_pkg::KIND_ERROR;
            n_phase          = wps_pkg::PH_RIFF_TAG;
            n_byte_index     = '0;
            n_tag_word       = '0;
            n_chunk_length   = '0;
            n_skip_remaining = '0;
            n_format_code    = '0;
            n_channel_count  = '0;
            n_sample_bits    = '0;
            n_low_byte_hold  = '0;
            n_byte_parity    = 1'b0;
            n_stereo_slot    = 1'b0;
        end else begin
            case (r_phase)
                wps_pkg::PH_RIFF_TAG, wps_pkg::PH_WAVE_TAG: begin
                    n_tag_word = shifted_tag;
                    if (r_byte_index != 4'd3) begin
                        n_byte_index = index_inc;
                    end else if (r_phase == wps_pkg::PH_RIFF_TAG
                                 && shifted_tag != wps_pkg::TAG_RIFF) begin
                        n_phase = wps_pkg::PH_DONE;
                        o_push  = 1'b1;
                    end else if (r_phase == wps_pkg::PH_WAVE_TAG
                                 && shifted_tag != wps_pkg::TAG_WAVE) begin
                        n_phase = wps_pkg::PH_DONE;
                        o_push  = 1'b1;
                    end else begin
                        n_phase        = (r_phase == wps_pkg::PH_RIFF_TAG)
                                         ? wps_pkg::PH_RIFF_SIZE : wps_pkg::PH_HDR_PRE;
                        n_byte_index   = '0;
                        n_tag_word     = '0;
                        n_chunk_length = '0;
                    end
                end
                wps_pkg::PH_RIFF_SIZE: begin
                    if (r_byte_index != 4'd3) begin
                        n_byte_index = index_inc;
                    end else begin
                        n_byte_index = '0;
                        n_phase      = wps_pkg::PH_WAVE_TAG;
                    end
                end
                wps_pkg::PH_HDR_PRE, wps_pkg::PH_HDR_POST: begin
                    // tag bytes first, then little-endian length
                    if (r_byte_index < 4'd4) begin
                        n_tag_word = shifted_tag;
                    end else begin
                        n_chunk_length = placed_len;
                    end
                    if (r_byte_index != 4'd7) begin
                        n_byte_index = index_inc;
                    end else begin
                        n_byte_index = '0;
                        if (r_phase == wps_pkg::PH_HDR_PRE
                            && r_tag_word == wps_pkg::TAG_FMT) begin
                            if (placed_len < wps_pkg::FMT_MIN_LEN) begin
                                n_phase = wps_pkg::PH_DONE;
                                o_push  = 1'b1;
                            end else begin
                                n_skip_remaining = placed_len - wps_pkg::FMT_MIN_LEN;
                                n_phase          = wps_pkg::PH_FMT_BODY;
                            end
                        end else if (r_phase == wps_pkg::PH_HDR_POST
                                     && r_tag_word == wps_pkg::TAG_DATA) begin
                            if (r_channel_count != wps_pkg::CHAN_MONO
                                && r_channel_count != wps_pkg::CHAN_STEREO) begin
                                n_phase = wps_pkg::PH_DONE;
                                o_push  = 1'b1;
                            end else begin
                                n_phase       = wps_pkg::PH_DATA;
                                n_byte_parity = 1'b0;
                                n_stereo_slot = 1'b0;
                            end
                        end else begin
                            n_skip_remaining = placed_len;
                            if (placed_len == 32'd0) begin
                                n_tag_word     = '0;
                                n_chunk_length = '0;
                            end else begin
                                n_phase = (r_phase == wps_pkg::PH_HDR_PRE)
                                          ? wps_pkg::PH_SKIP_PRE : wps_pkg::PH_SKIP_POST;
                            end
                        end
                    end
                end
                wps_pkg::PH_SKIP_PRE, wps_pkg::PH_SKIP_POST: begin
                    n_skip_remaining = r_skip_remaining - 32'd1;
                    if (n_skip_remaining == 32'd0) begin
                        n_phase        = (r_phase == wps_pkg::PH_SKIP_PRE)
                                         ? wps_pkg::PH_HDR_PRE : wps_pkg::PH_HDR_POST;
                        n_byte_index   = '0;
                        n_tag_word     = '0;
                        n_chunk_length = '0;
                    end
                end
                wps_pkg::PH_FMT_BODY: begin
                    // pick format, channel and bit depth out of the fmt body
                    case (r_byte_index)
                        4'd0:    n_format_code   = {r_format_code[15:8], i_byte};
                        4'd1:    n_format_code   = {i_byte, r_format_code[7:0]};
                        4'd2:    n_channel_count = {r_channel_count[15:8], i_byte};
                        4'd3:    n_channel_count = {i_byte, r_channel_count[7:0]};
                        4'd14:   n_sample_bits   = {r_sample_bits[15:8], i_byte};
                        4'd15:   n_sample_bits   = full_bits;
                        default: n_format_code   = r_format_code;
                    endcase
                    if (r_byte_index != 4'd15) begin
                        n_byte_index = index_inc;
                    end else begin
                        n_byte_index = '0;
                        if (r_format_code != wps_pkg::FMT_PCM
                            || full_bits != wps_pkg::BITS_16) begin
                            n_phase = wps_pkg::PH_DONE;
                            o_push  = 1'b1;
                        end else if (r_skip_remaining == 32'd0) begin
                            n_phase        = wps_pkg::PH_HDR_POST;
                            n_tag_word     = '0;
                            n_chunk_length = '0;
                        end else begin
                            n_phase = wps_pkg::PH_SKIP_POST;
                        end
                    end
                end
                wps_pkg::PH_DATA: begin
                    // low byte held, high byte completes a sample
                    if (!r_byte_parity) begin
                        n_low_byte_hold = i_byte;
                        n_byte_parity   = 1'b1;
                    end else begin
                        n_byte_parity  = 1'b0;
                        o_push         = 1'b1;
                        o_entry.kind   = wps_pkg::KIND_SAMPLE;
                        o_entry.sample = {i_byte, r_low_byte_hold};
                        if (r_channel_count == wps_pkg::CHAN_MONO) begin
                            o_entry.dual = 1'b1;
                        end else begin
                            o_entry.right = r_stereo_slot;
                            n_stereo_slot = ~r_stereo_slot;
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= wps_pkg::PH_RIFF_TAG;
            r_byte_index     <= '0;
            r_tag_word       <= '0;
            r_chunk_length   <= '0;
            r_skip_remaining <= '0;
            r_format_code    <= '0;
            r_channel_count  <= '0;
            r_sample_bits    <= '0;
            r_low_byte_hold  <= '0;
            r_byte_parity    <= 1'b0;
            r_stereo_slot    <= 1'b0;
        end else if (i_accept) begin
            r_phase          <= n_phase;
            r_byte_index     <= n_byte_index;
            r_tag_word       <= n_tag_word;
            r_chunk_length   <= n_chunk_length;
            r_skip_remaining <= n_skip_remaining;
            r_format_code    <= n_format_code;
            r_channel_count  <= n_channel_count;
            r_sample_bits    <= n_sample_bits;
            r_low_byte_hold  <= n_low_byte_hold;
            r_byte_parity    <= n_byte_parity;
            r_stereo_slot    <= n_stereo_slot;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/wps_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none

module wps_out_buf (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire wps_pkg::t_entry i_entry,
    output logic                 o_ready,
    output logic                 o_valid,
    input  wire logic            i_taken,
    output logic [1:0]           o_kind,
    output logic signed [15:0]   o_sample,
    output logic                 o_right,
    output logic                 o_last
);

    wps_pkg::t_entry    r_mem [2];
    logic               r_wr_ptr;
    logic               r_rd_ptr;
    logic [1:0]         r_count;
    logic               r_sub;
    wps_pkg::t_entry    head;
    logic               pop;

    assign head     = r_mem[r_rd_ptr];
    assign o_ready  = (r_count != 2'd2);
    assign o_valid  = (r_count != 2'd0);
    assign o_kind   = head.kind;
    assign o_sample = head.sample;
    assign o_right  = head.dual ? r_sub : head.right;
    assign o_last   = !head.dual || r_sub;
    assign pop      = o_valid && i_taken && o_last;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // pointers, fill count and beat within a dual entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
            r_sub    <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
                r_sub    <= 1'b0;
            end else if (o_valid && i_taken) begin
                r_sub    <= 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hdl/wav_pcm16_stream_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none
// a result entry is registered into the result queue as the byte that causes it is accepted
// throughput: one file byte per cycle while the result queue has room, set by the single-pass parser update
// a mono sample's two beats drain while its next two bytes arrive, so the rate holds
// the two-entry result queue lets a new byte in while a finished result waits
// reset: i_rst_n synchronous, active low; parser returns to expecting the RIFF tag

module wav_pcm16_stream_parser_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire logic [7:0]    i_s_tdata,   // [7:0] file_byte
    input  wire logic          i_s_tuser,   // [0] op
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output logic [15:0]        o_m_tdata,   // [15:0] sample
    output logic [2:0]         o_m_tuser,   // [1:0] kind, [2] right_channel
    output logic               o_m_tlast    // last_of_run
);

    logic               accept;
    logic               push;
    wps_pkg::t_entry    entry;
    logic [1:0]         out_kind;
    logic signed [15:0] out_sample;
    logic               out_right;

    assign accept = i_s_tvalid && o_s_tready;

    // byte parser
    wps_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_op     (i_s_tuser),
        .i_byte   (i_s_tdata),
        .o_entry  (entry),
        .o_push   (push)
    );

    // result queue and beat sequencer
    wps_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push && accept),
        .i_entry  (entry),
        .o_ready  (o_s_tready),
        .o_valid  (o_m_tvalid),
        .i_taken  (i_m_tready),
        .o_kind   (out_kind),
        .o_sample (out_sample),
        .o_right  (out_right),
        .o_last   (o_m_tlast)
    );

    assign o_m_tdata = out_sample;
    assign o_m_tuser = {out_right, out_kind};

endmodule

`default_nettype wire

FILE: hdl/wps_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module wps_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          o_m_tvalid,
    input  wire logic          i_m_tready,
    input  wire logic [15:0]   o_m_tdata,
    input  wire logic [2:0]    o_m_tuser,
    input  wire logic          o_m_tlast
);

    // a stalled result beat stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result beat dropped while stalled");

    // status beats carry no sample, sit in the left slot and close the run
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1:0] != wps_pkg::KIND_SAMPLE
        |-> o_m_tlast && o_m_tdata == 16'd0 && !o_m_tuser[2])
        else $error("status beat with sample, slot or open run");

    // no undefined kind code
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tuser[1:0] != 2'd3)
        else $error("undefined result kind");

    // the left copy of a mono sample is followed at once by the right copy
    a_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast
        |=> o_m_tvalid && o_m_tuser[2] && o_m_tuser[1:0] == wps_pkg::KIND_SAMPLE
            && o_m_tdata == $past(o_m_tdata))
        else $error("mono pair broken");

    // a non-final beat is only the left copy of a sample
    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast
        |-> o_m_tuser[1:0] == wps_pkg::KIND_SAMPLE && !o_m_tuser[2])
        else $error("open run on a beat other than a left sample");

endmodule

bind wav_pcm16_stream_parser_core wps_checker u_wps_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire

FILE: tb/sv/wps_stream_checker.sv
`timescale 1ns / 1ps

// watches both stream channels, predicts the parser and compares result beats in order
module wps_stream_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [7:0]  i_s_tdata,    // [7:0] file_byte
    input  wire logic        i_s_tuser,    // [0] op
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [15:0] i_m_tdata,    // [15:0] sample
    input  wire logic [2:0]  i_m_tuser,    // [1:0] kind, [2] right_channel
    input  wire logic        i_m_tlast,    // last_of_run
    output int               o_fail_count,
    output int               o_pending,
    output int               o_beats_checked
);

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] sample;
        logic               right;
        logic               last;
    } t_audio_beat;

    // predicted parser state
    wps_pkg::t_phase prs_phase;
    logic [3:0]      hdr_pos;
    logic [31:0]     tag_acc;
    logic [31:0]     len_acc;
    logic [31:0]     skip_left;
    logic [15:0]     fmt_code;
    logic [15:0]     fmt_chans;
    logic [15:0]     fmt_bits;
    logic [7:0]      lo_byte;
    logic            have_lo;
    logic            slot_right;

    t_audio_beat beats_due[$];
    int          mismatches = 0;
    int          checked = 0;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic clear_parser();
        prs_phase  = wps_pkg::PH_RIFF_TAG;
        hdr_pos    = '0;
        tag_acc    = '0;
        len_acc    = '0;
        skip_left  = '0;
        fmt_code   = '0;
        fmt_chans  = '0;
        fmt_bits   = '0;
        lo_byte    = '0;
        have_lo    = 1'b0;
        slot_right = 1'b0;
    endtask

    task automatic start_header(input wps_pkg::t_phase next_phase);
        prs_phase = next_phase;
        hdr_pos   = '0;
        tag_acc   = '0;
        len_acc   = '0;
    endtask

    task automatic push_beat(input logic [1:0] kind, input logic [15:0] smp,
                             input logic right, input logic last);
        t_audio_beat nb;
        nb.kind   = kind;
        nb.sample = smp;
        nb.right  = right;
        nb.last   = last;
        beats_due.push_back(nb);
    endtask

    // a bad field parks the parser until end of file
    task automatic flag_error();
        prs_phase = wps_pkg::PH_DONE;
        push_beat(wps_pkg::KIND_ERROR, 16'd0, 1'b0, 1'b1);
    endtask

    // one accepted input beat through the parser
    task automatic parse_item(input logic op, input logic [7:0] b);
        wps_pkg::t_phase was;
        logic [15:0]     word;
        if (op == wps_pkg::OP_EOF) begin
            was = prs_phase;
            clear_parser();
            if (was != wps_pkg::PH_DONE)
                push_beat((was == wps_pkg::PH_DATA) ? wps_pkg::KIND_END_OK
                                                    : wps_pkg::KIND_ERROR,
                          16'd0, 1'b0, 1'b1);
        end else begin
            case (prs_phase)
                wps_pkg::PH_RIFF_TAG, wps_pkg::PH_WAVE_TAG: begin
                    tag_acc = {tag_acc[23:0], b};
                    if (hdr_pos != 4'd3) begin
                        hdr_pos = hdr_pos + 4'd1;
                    end else if (prs_phase == wps_pkg::PH_RIFF_TAG) begin
                        if (tag_acc != wps_pkg::TAG_RIFF) begin
                            flag_error();
                        end else begin
                            prs_phase = wps_pkg::PH_RIFF_SIZE;
                            hdr_pos   = '0;
                            tag_acc   = '0;
                        end
                    end else begin
                        if (tag_acc != wps_pkg::TAG_WAVE) flag_error();
                        else start_header(wps_pkg::PH_HDR_PRE);
                    end
                end
                wps_pkg::PH_RIFF_SIZE: begin
                    if (hdr_pos != 4'd3) begin
                        hdr_pos = hdr_pos + 4'd1;
                    end else begin
                        hdr_pos   = '0;
                        prs_phase = wps_pkg::PH_WAVE_TAG;
                    end
                end
                wps_pkg::PH_HDR_PRE, wps_pkg::PH_HDR_POST: begin
                    // tag arrives first byte high, length little-endian
                    if (hdr_pos < 4'd4) tag_acc = {tag_acc[23:0], b};
                    else len_acc = len_acc | ({24'd0, b} << (8 * (hdr_pos - 4'd4)));
                    if (hdr_pos != 4'd7) begin
                        hdr_pos = hdr_pos + 4'd1;
                    end else begin
                        hdr_pos = '0;
                        if (prs_phase == wps_pkg::PH_HDR_PRE
                            && tag_acc == wps_pkg::TAG_FMT) begin
                            if (len_acc < wps_pkg::FMT_MIN_LEN) begin
                                flag_error();
                            end else begin
                                skip_left = len_acc - wps_pkg::FMT_MIN_LEN;
                                prs_phase = wps_pkg::PH_FMT_BODY;
                            end
                        end else if (prs_phase == wps_pkg::PH_HDR_POST
                                     && tag_acc == wps_pkg::TAG_DATA) begin
                            if (fmt_chans != wps_pkg::CHAN_MONO
                                && fmt_chans != wps_pkg::CHAN_STEREO) begin
                                flag_error();
                            end else begin
                                prs_phase  = wps_pkg::PH_DATA;
                                have_lo    = 1'b0;
                                slot_right = 1'b0;
                            end
                        end else begin
                            // any other chunk is skipped, an empty one right away
                            skip_left = len_acc;
                            if (skip_left == 32'd0) start_header(prs_phase);
                            else if (prs_phase == wps_pkg::PH_HDR_PRE)
                                prs_phase = wps_pkg::PH_SKIP_PRE;
                            else prs_phase = wps_pkg::PH_SKIP_POST;
                        end
                    end
                end
                wps_pkg::PH_SKIP_PRE, wps_pkg::PH_SKIP_POST: begin
                    skip_left = skip_left - 32'd1;
                    if (skip_left == 32'd0) begin
                        if (prs_phase == wps_pkg::PH_SKIP_PRE)
                            start_header(wps_pkg::PH_HDR_PRE);
                        else start_header(wps_pkg::PH_HDR_POST);
                    end
                end
                wps_pkg::PH_FMT_BODY: begin
                    case (hdr_pos)
                        4'd0:    fmt_code[7:0]   = b;
                        4'd1:    fmt_code[15:8]  = b;
                        4'd2:    fmt_chans[7:0]  = b;
                        4'd3:    fmt_chans[15:8] = b;
                        4'd14:   fmt_bits[7:0]   = b;
                        4'd15:   fmt_bits[15:8]  = b;
                        default: ;
                    endcase
                    if (hdr_pos != 4'd15) begin
                        hdr_pos = hdr_pos + 4'd1;
                    end else begin
                        hdr_pos = '0;
                        if (fmt_code != wps_pkg::FMT_PCM || fmt_bits != wps_pkg::BITS_16)
                            flag_error();
                        else if (skip_left == 32'd0) start_header(wps_pkg::PH_HDR_POST);
                        else prs_phase = wps_pkg::PH_SKIP_POST;
                    end
                end
                wps_pkg::PH_DATA: begin
                    // byte pairs make samples, mono goes out in both slots
                    if (!have_lo) begin
                        lo_byte = b;
                        have_lo = 1'b1;
                    end else begin
                        have_lo = 1'b0;
                        word    = {b, lo_byte};
                        if (fmt_chans == wps_pkg::CHAN_MONO) begin
                            push_beat(wps_pkg::KIND_SAMPLE, word, 1'b0, 1'b0);
                            push_beat(wps_pkg::KIND_SAMPLE, word, 1'b1, 1'b1);
                        end else begin
                            push_beat(wps_pkg::KIND_SAMPLE, word, slot_right, 1'b1);
                            slot_right = ~slot_right;
                        end
                    end
                end
                default: ;
            endcase
        end
    endtask

    // sample both channels at the clock edge
    always @(posedge i_clk) begin
        t_audio_beat want;
        if (!i_rst_n) begin
            clear_parser();
            beats_due.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) parse_item(i_s_tuser, i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                if (beats_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat: kind %0d sample %0d right %0b",
                                              i_m_tuser[1:0], $signed(i_m_tdata),
                                              i_m_tuser[2]));
                end else begin
                    want = beats_due.pop_front();
                    if (i_m_tuser[1:0] !== want.kind || i_m_tdata !== want.sample ||
                        i_m_tuser[2] !== want.right || i_m_tlast !== want.last)
                        report_mismatch($sformatf(
                            "beat %0d: got %0d/%0d/%0b/%0b want %0d/%0d/%0b/%0b (kind/smp/r/last)",
                            checked, i_m_tuser[1:0], $signed(i_m_tdata), i_m_tuser[2],
                            i_m_tlast, want.kind, want.sample, want.right, want.last));
                end
                checked++;
            end
        end
        o_pending       <= beats_due.size();
        o_fail_count    <= mismatches;
        o_beats_checked <= checked;
    end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 8;
    localparam int TARGET_BYTES   = 460;
    localparam int IDLE_PCT       = 35;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES   = 10;
    localparam int CYCLE_LIMIT    = 300000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'd0;
    logic        i_s_tuser = wps_pkg::OP_BYTE;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;
    logic [2:0]  o_m_tuser;
    logic        o_m_tlast;

    int fail_count;
    int beats_pending;
    int beats_checked;

    int items_sent = 0;
    int files_sent = 0;
    int cycle_count = 0;
    bit steady = 1'b0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    logic [7:0] file_bytes[$];

    wav_pcm16_stream_parser_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    wps_stream_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (i_s_tvalid),
        .i_s_tready      (o_s_tready),
        .i_s_tdata       (i_s_tdata),
        .i_s_tuser       (i_s_tuser),
        .i_m_tvalid      (o_m_tvalid),
        .i_m_tready      (i_m_tready),
        .i_m_tdata       (o_m_tdata),
        .i_m_tuser       (o_m_tuser),
        .i_m_tlast       (o_m_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (beats_pending),
        .o_beats_checked (beats_checked)
    );

    // clock
    always #(CLK_HALF) i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, beats_pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off when asked
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                i_m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                i_m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // tags go first byte high
    task automatic put_tag(input logic [31:0] tag);
        file_bytes.push_back(tag[31:24]);
        file_bytes.push_back(tag[23:16]);
        file_bytes.push_back(tag[15:8]);
        file_bytes.push_back(tag[7:0]);
    endtask

    task automatic put_le16(input logic [15:0] v);
        file_bytes.push_back(v[7:0]);
        file_bytes.push_back(v[15:8]);
    endtask

    task automatic put_le32(input logic [31:0] v);
        put_le16(v[15:0]);
        put_le16(v[31:16]);
    endtask

    // offer one beat, called at a clock edge, returns at the accepting edge
    task automatic send_item(input logic op, input logic [7:0] b);
        if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < IDLE_PCT) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // the built bytes, then the end-of-file mark with a junk byte
    task automatic send_file();
        foreach (file_bytes[k]) send_item(wps_pkg::OP_BYTE, file_bytes[k]);
        send_item(wps_pkg::OP_EOF, 8'($urandom));
        files_sent++;
    endtask

    // sender goes quiet until every predicted result is out
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (beats_pending != 0) @(posedge i_clk);
    endtask

    // wav image with random side chunks; faulty ones may break a field or get cut short
    task automatic build_wav(input bit faulty, input int data_len, input logic [15:0] chans);
        int          fmt_len;
        int          skip_len;
        int          cut;
        logic [15:0] code;
        logic [15:0] bits;
        logic [31:0] tag;
        file_bytes.delete();
        code    = wps_pkg::FMT_PCM;
        bits    = wps_pkg::BITS_16;
        fmt_len = 16 + (($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0);
        if (faulty) begin
            case ($urandom_range(0, 11))
                0:       fmt_len = $urandom_range(0, 15);
                1:       code = 16'($urandom);
                2:       bits = 16'($urandom_range(0, 32));
                3:       chans = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(3, 65535));
                default: ;
            endcase
        end
        put_tag(wps_pkg::TAG_RIFF);
        put_le32($urandom);
        put_tag(wps_pkg::TAG_WAVE);
        // chunks ahead of fmt, a data chunk there gets skipped too
        repeat ($urandom_range(0, 2)) begin
            tag      = $urandom_range(0, 1) ? wps_pkg::TAG_DATA : $urandom;
            skip_len = $urandom_range(0, 5);
            put_tag(tag);
            put_le32(skip_len);
            repeat (skip_len) file_bytes.push_back(8'($urandom));
        end
        put_tag(wps_pkg::TAG_FMT);
        put_le32(fmt_len);
        put_le16(code);
        put_le16(chans);
        put_le32($urandom);
        put_le32($urandom);
        put_le16(16'($urandom));
        put_le16(bits);
        if (fmt_len > 16) repeat (fmt_len - 16) file_bytes.push_back(8'($urandom));
        // chunks between fmt and data, a second fmt among them is just skipped
        repeat ($urandom_range(0, 2)) begin
            tag      = $urandom_range(0, 1) ? wps_pkg::TAG_FMT : $urandom;
            skip_len = $urandom_range(0, 4);
            put_tag(tag);
            put_le32(skip_len);
            repeat (skip_len) file_bytes.push_back(8'($urandom));
        end
        put_tag(wps_pkg::TAG_DATA);
        put_le32($urandom);
        // sample bytes, leaning on full-scale values
        repeat (data_len) begin
            case ($urandom_range(0, 7))
                0:       file_bytes.push_back(8'h00);
                1:       file_bytes.push_back(8'hFF);
                2:       file_bytes.push_back($urandom_range(0, 1) ? 8'h7F : 8'h80);
                default: file_bytes.push_back(8'($urandom));
            endcase
        end
        if (faulty) begin
            case ($urandom_range(0, 9))
                0: file_bytes[$urandom_range(0, 43)] = 8'($urandom);
                1: begin
                    cut = $urandom_range(0, file_bytes.size() - 1);
                    while (file_bytes.size() > cut) void'(file_bytes.pop_back());
                end
                default: ;
            endcase
        end
    endtask

    // stimulus and verdict
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // end of file on an empty stream
        file_bytes.delete();
        send_file();
        // bad riff tag, bytes after it ignored, quiet end of file
        put_tag(wps_pkg::TAG_RIFF ^ 32'h0000_0001);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'h00);
        send_file();
        // good riff, bad wave tag
        file_bytes.delete();
        put_tag(wps_pkg::TAG_RIFF);
        put_le32(32'hFFFF_FFFF);
        put_tag(wps_pkg::TAG_WAVE ^ 32'h0000_0100);
        send_file();
        wait_drained();

        // long mono file while the result side holds off
        hold_req = 1'b1;
        build_wav(1'b0, 48, wps_pkg::CHAN_MONO);
        send_file();
        wait_drained();

        // random files, mostly well-formed, some broken and some noise
        while (items_sent < TARGET_BYTES) begin
            steady = (files_sent >= 6 && files_sent <= 8);
            if ($urandom_range(0, 11) == 0) begin
                file_bytes.delete();
                if ($urandom_range(0, 1)) put_tag(wps_pkg::TAG_RIFF);
                repeat ($urandom_range(1, 12)) file_bytes.push_back(8'($urandom));
            end else begin
                build_wav(1'b1, $urandom_range(0, 24),
                          $urandom_range(0, 1) ? wps_pkg::CHAN_MONO : wps_pkg::CHAN_STEREO);
            end
            send_file();
            if (files_sent % 4 == 0) wait_drained();
        end
        steady = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d files (%0d input beats): tag, format, truncation and data cases",
                 files_sent, items_sent);
        $display("%0d result beats compared, %0d mismatches", beats_checked, fail_count);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
